[design/wtvn_pkg.sv]
// Shared types and constants of the weighted total variation norm block.
package wtvn_pkg;

	localparam int ACC_W  = 48;
	localparam int WGT_W  = 16;
	localparam int FRAC_W = 12;
	localparam int CFG_W  = 11;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register word indexes (byte address bits [3:2])
	localparam logic [1:0] REG_ROWS    = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_WEIGHTS = 2'd2;

	localparam logic [CFG_W-1:0] ROWS_RESET    = 11'd256;
	localparam logic [CFG_W-1:0] COLUMNS_RESET = 11'd256;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDQ,
		S_RDK,
		S_LOAD,
		S_MUL,
		S_SQI,
		S_SQRT,
		S_WR
	} wtvn_state_t;

endpackage

[design/wtvn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wtvn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/weighted_total_variation_norm.sv]
// Weighted isotropic total variation norm over a streamed complex image.
//
// Pixels enter on the in_valid/in_ready channel in column-major order, row
// index fastest, each with its own down and across weights (Q4.12). One
// transfer per pixel; one tv_total transfer on the out channel after the
// final pixel of each image (rows x columns pixels).
// Each pixel takes a transfer, two line memory reads, then up to two
// gradient magnitudes. A magnitude passes through the shared scale/square
// multipliers and then the bit-serial square root; a new pixel is accepted
// only once the previous one is written back. The line buffer is one RAM of
// MAX_ROWS+1 entries.
// The total waits in an output register; the next image proceeds while it
// waits, and only the final pixel of the following image stalls if the
// receiver has still not taken it.
// Reset clears indexes and accumulator and sets rows=columns=256, weights
// off; no clearing pass is needed. Writing rows or columns restarts the image.
module weighted_total_variation_norm #(
	parameter int MAX_ROWS    = 1024,
	parameter int MAX_COLUMNS = 1024,
	parameter int PIXEL_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wtvn_pkg::ADDR_W-1:0]         paddr,
	input  logic [wtvn_pkg::DATA_W-1:0]         pwdata,
	output logic [wtvn_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [PIXEL_BITS-1:0]        pixel_re,
	input  logic signed [PIXEL_BITS-1:0]        pixel_im,
	input  logic [wtvn_pkg::WGT_W-1:0]          weight_down,
	input  logic [wtvn_pkg::WGT_W-1:0]          weight_across,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wtvn_pkg::ACC_W-1:0]          tv_total
);
	import wtvn_pkg::*;

	localparam int DEPTH = MAX_ROWS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int NRW   = $clog2(MAX_ROWS + 1);
	localparam int NCW   = $clog2(MAX_COLUMNS + 1);
	localparam int DW    = PIXEL_BITS + 1;
	localparam int SW    = PIXEL_BITS + 5;
	localparam int SQW   = 2 * SW + 2;
	localparam int MW    = DW + WGT_W + 1;
	localparam int LW    = 2 * PIXEL_BITS + 2 * WGT_W;

	// configuration registers
	logic [CFG_W-1:0] rows_q, columns_q;
	logic             use_w_q;
	logic             cfg_wr;

	// control state
	wtvn_state_t state_q, state_d;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    col_q;
	logic [AW-1:0]    wr_q;
	logic [ACC_W-1:0] acc_q;
	logic             phase_q;
	logic [2:0]       cnt_q;
	logic             out_valid_q;
	logic [ACC_W-1:0] tv_q;

	// payload registers
	logic signed [PIXEL_BITS-1:0] cur_re_q, cur_im_q, prev_re_q, prev_im_q;
	logic [WGT_W-1:0]             cur_wd_q, cur_wa_q, prev_wd_q;
	logic [LW-1:0]                q_ent_q;
	logic signed [DW-1:0]         term_q [4];
	logic [WGT_W-1:0]             tw_q [2];
	logic [SW-1:0]                scaled_s1;
	logic [SQW-1:0]               sumsq_q, v_q, r_q, bit_q;

	// derived geometry of the current image
	logic [NRW-1:0] nr;
	logic [NCW-1:0] nc;
	logic           restart, ilast, jfirst, jlast, bneed, last, out_free;
	logic [31:0]    tq, tk;
	logic [AW-1:0]  q_addr, k_addr, raddr;
	logic [LW-1:0]  rdata;
	logic           ram_we;
	logic           accept;

	// datapath nets
	logic signed [PIXEL_BITS-1:0] q_re, q_im, k_re, k_im;
	logic [WGT_W-1:0]             q_wd, q_wa;
	logic signed [DW-1:0]         tsel;
	logic [DW-1:0]                mag;
	logic [MW-1:0]                prod;
	logic [SW-1:0]                scaled_d;
	logic [2*SW-1:0]              sq;
	logic [SQW-1:0]               rb, v_n, r_n;
	logic [ACC_W:0]               acc_sum;
	logic [ACC_W-1:0]             acc_n;

	// APB port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_ROWS:    prdata = DATA_W'(rows_q);
			REG_COLUMNS: prdata = DATA_W'(columns_q);
			REG_WEIGHTS: prdata = DATA_W'(use_w_q);
			default:     prdata = '0;
		endcase
	end

	// dimension clamping
	always_comb begin
		if (32'(rows_q) < 2) nr = NRW'(2);
		else if (32'(rows_q) > MAX_ROWS) nr = NRW'(MAX_ROWS);
		else nr = NRW'(rows_q);
		if (32'(columns_q) < 2) nc = NCW'(2);
		else if (32'(columns_q) > MAX_COLUMNS) nc = NCW'(MAX_COLUMNS);
		else nc = NCW'(columns_q);
	end

	assign restart  = (32'(row_q) >= 32'(nr)) || (32'(col_q) >= 32'(nc));
	assign ilast    = 32'(row_q) == 32'(nr) - 1;
	assign jfirst   = col_q == '0;
	assign jlast    = 32'(col_q) == 32'(nc) - 1;
	assign bneed    = jlast && (row_q != '0);
	assign last     = ilast && jlast;
	assign out_free = !out_valid_q || out_ready;

	// line history addresses: nr and nr-1 entries back
	assign tq     = 32'(wr_q) + DEPTH - 32'(nr);
	assign tk     = 32'(wr_q) + DEPTH + 1 - 32'(nr);
	assign q_addr = (tq >= DEPTH) ? AW'(tq - DEPTH) : AW'(tq);
	assign k_addr = (tk >= DEPTH) ? AW'(tk - DEPTH) : AW'(tk);
	assign raddr  = (state_q == S_RDK) ? k_addr : q_addr;
	assign ram_we = (state_q == S_WR) && (!last || out_free);

	wtvn_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_q),
		.wdata({cur_re_q, cur_im_q, cur_wd_q, cur_wa_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign {q_re, q_im, q_wd, q_wa} = q_ent_q;
	assign k_re = rdata[LW-1 -: PIXEL_BITS];
	assign k_im = rdata[LW-PIXEL_BITS-1 -: PIXEL_BITS];

	// scale stage: |d|, times weight rounded half up when weighting is on
	assign tsel     = term_q[cnt_q[1:0]];
	assign mag      = tsel[DW-1] ? DW'(-tsel) : DW'(tsel);
	assign prod     = MW'(mag) * MW'(tw_q[cnt_q[1]]) + MW'(1 << (FRAC_W - 1));
	assign scaled_d = use_w_q ? SW'(prod >> FRAC_W) : SW'(mag);
	assign sq       = scaled_s1 * scaled_s1;

	// one square root digit
	assign rb = r_q + bit_q;
	always_comb begin
		if (v_q >= rb) begin
			v_n = v_q - rb;
			r_n = (r_q >> 1) + bit_q;
		end else begin
			v_n = v_q;
			r_n = r_q >> 1;
		end
	end

	assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(r_n[SW:0]);
	assign acc_n   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign tv_total  = tv_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_RDQ;
			S_RDQ:  state_d = S_RDK;
			S_RDK:  state_d = S_LOAD;
			S_LOAD: state_d = jfirst ? S_WR : S_MUL;
			S_MUL:  if (cnt_q == 3'd4) state_d = S_SQI;
			S_SQI:  state_d = S_SQRT;
			S_SQRT: begin
				if (bit_q[0]) state_d = (!phase_q && bneed) ? S_MUL : S_WR;
			end
			S_WR:   if (!last || out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= ROWS_RESET;
			columns_q   <= COLUMNS_RESET;
			use_w_q     <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			wr_q        <= '0;
			acc_q       <= '0;
			phase_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// total presented on the final write-back, dropped on its transfer
			if (state_q == S_WR && last && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_ROWS, REG_COLUMNS: begin
						if (paddr[3:2] == REG_ROWS) rows_q <= pwdata[CFG_W-1:0];
						else columns_q <= pwdata[CFG_W-1:0];
						row_q <= '0;
						col_q <= '0;
						wr_q  <= '0;
						acc_q <= '0;
					end
					REG_WEIGHTS: use_w_q <= pwdata[0];
					default: ;
				endcase
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept && restart) begin
							row_q <= '0;
							col_q <= '0;
							wr_q  <= '0;
							acc_q <= '0;
						end
					end
					S_LOAD: begin
						phase_q <= 1'b0;
						cnt_q   <= '0;
					end
					S_MUL:  cnt_q <= cnt_q + 3'd1;
					S_SQRT: begin
						if (bit_q[0]) begin
							acc_q   <= acc_n;
							phase_q <= 1'b1;
							cnt_q   <= '0;
						end
					end
					S_WR: begin
						if (last && out_free) begin
							row_q <= '0;
							col_q <= '0;
							wr_q  <= '0;
							acc_q <= '0;
						end else if (!last) begin
							wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + AW'(1);
							if (ilast) begin
								row_q <= '0;
								col_q <= col_q + CW'(1);
							end else begin
								row_q <= row_q + RW'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_re_q <= pixel_re;
			cur_im_q <= pixel_im;
			cur_wd_q <= weight_down;
			cur_wa_q <= weight_across;
		end
		if (state_q == S_RDK) q_ent_q <= rdata;
		// along-column and across terms of the previous column's position
		if (state_q == S_LOAD) begin
			term_q[0] <= ilast ? '0 : DW'(k_re) - DW'(q_re);
			term_q[1] <= ilast ? '0 : DW'(k_im) - DW'(q_im);
			term_q[2] <= DW'(cur_re_q) - DW'(q_re);
			term_q[3] <= DW'(cur_im_q) - DW'(q_im);
			tw_q[0]   <= q_wd;
			tw_q[1]   <= q_wa;
			sumsq_q   <= '0;
		end
		// last column: along-column term of the previous row
		if (state_q == S_SQRT && bit_q[0]) begin
			term_q[0] <= DW'(cur_re_q) - DW'(prev_re_q);
			term_q[1] <= DW'(cur_im_q) - DW'(prev_im_q);
			term_q[2] <= '0;
			term_q[3] <= '0;
			tw_q[0]   <= prev_wd_q;
			tw_q[1]   <= '0;
			sumsq_q   <= '0;
		end
		if (state_q == S_MUL) begin
			if (cnt_q != 3'd4) scaled_s1 <= scaled_d;
			if (cnt_q != 3'd0) sumsq_q <= sumsq_q + SQW'(sq);
		end
		if (state_q == S_SQI) begin
			v_q   <= sumsq_q;
			r_q   <= '0;
			bit_q <= SQW'(1) << (SQW - 2);
		end
		if (state_q == S_SQRT) begin
			v_q   <= v_n;
			r_q   <= r_n;
			bit_q <= bit_q >> 2;
		end
		if (ram_we) begin
			prev_re_q <= cur_re_q;
			prev_im_q <= cur_im_q;
			prev_wd_q <= cur_wd_q;
		end
		if (state_q == S_WR && last && out_free) tv_q <= acc_q;
	end

	// checks
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while an item is in work");
	a_out_from_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WR))
		else $error("total presented outside the write-back step");
	a_sqrt_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> $onehot(bit_q))
		else $error("square root digit marker lost");
endmodule

[bench/wtvn_checker.sv]
`timescale 1ns / 100ps
// Transfer monitor, total variation predictor and result comparison for the TV norm block.
module wtvn_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [wtvn_pkg::ADDR_W-1:0] paddr,
	input  logic [wtvn_pkg::DATA_W-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic signed [15:0]          pixel_re,
	input  logic signed [15:0]          pixel_im,
	input  logic [15:0]                 weight_down,
	input  logic [15:0]                 weight_across,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [wtvn_pkg::ACC_W-1:0]  tv_total,
	output int                          errors,
	output int                          pending,
	output int                          totals_seen
);
	import wtvn_pkg::*;

	localparam int DIM_MAX = 1024;
	localparam int DEPTH   = DIM_MAX + 1;
	localparam logic [ACC_W-1:0] ACC_SAT = {ACC_W{1'b1}};

	// model copy of the registers and the line store
	logic [CFG_W-1:0] rows_reg, cols_reg;
	logic             weights_on;
	int               hist_re [DEPTH];
	int               hist_im [DEPTH];
	int               hist_wd [DEPTH];
	int               hist_wa [DEPTH];
	int               row_pos, col_pos, wr_pos;
	logic [ACC_W-1:0] tv_sum;
	logic [ACC_W-1:0] total_expected_q[$];

	function automatic longint unsigned grad_scale(int d, int w, logic on);
		longint unsigned m;
		m = (d < 0) ? longint'(-d) : longint'(d);
		if (!on)
			return m;
		return (m * longint'(w) + 64'd2048) >> FRAC_W;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			b = r | (64'd1 << k);
			if (b * b <= v)
				r = b;
		end
		return r;
	endfunction

	function automatic longint unsigned grad_mag(int dxr, int dxi, int wd,
			int dyr, int dyi, int wa, logic on);
		longint unsigned a, b, c, e;
		a = grad_scale(dxr, wd, on);
		b = grad_scale(dxi, wd, on);
		c = grad_scale(dyr, wa, on);
		e = grad_scale(dyi, wa, on);
		return floor_root(a * a + b * b + c * c + e * e);
	endfunction

	function automatic int back(int d);
		return (wr_pos + DEPTH - (d % DEPTH)) % DEPTH;
	endfunction

	task automatic restart_image();
		row_pos = 0;
		col_pos = 0;
		wr_pos  = 0;
		tv_sum  = '0;
	endtask

	// predict one pixel transfer
	task automatic take_pixel(int cre, int cim, int wd, int wa);
		int nr, nc, q, k, dxr, dxi;
		longint unsigned add, acc;
		nr = rows_reg;
		nc = cols_reg;
		add = 0;
		if (nr < 2) nr = 2;
		if (nr > DIM_MAX) nr = DIM_MAX;
		if (nc < 2) nc = 2;
		if (nc > DIM_MAX) nc = DIM_MAX;
		if (row_pos >= nr || col_pos >= nc)
			restart_image();
		// finishes the position one column back
		if (col_pos > 0) begin
			q = back(nr);
			dxr = 0;
			dxi = 0;
			if (row_pos < nr - 1) begin
				k = back(nr - 1);
				dxr = hist_re[k] - hist_re[q];
				dxi = hist_im[k] - hist_im[q];
			end
			add += grad_mag(dxr, dxi, hist_wd[q], cre - hist_re[q], cim - hist_im[q],
				hist_wa[q], weights_on);
		end
		// last column also finishes the pixel above
		if (col_pos == nc - 1 && row_pos > 0) begin
			k = back(1);
			add += grad_mag(cre - hist_re[k], cim - hist_im[k], hist_wd[k], 0, 0, 0,
				weights_on);
		end
		acc = longint'(tv_sum) + add;
		tv_sum = (acc > longint'(ACC_SAT)) ? ACC_SAT : acc[ACC_W-1:0];
		hist_re[wr_pos] = cre;
		hist_im[wr_pos] = cim;
		hist_wd[wr_pos] = wd;
		hist_wa[wr_pos] = wa;
		wr_pos = (wr_pos + 1) % DEPTH;
		if (row_pos == nr - 1 && col_pos == nc - 1) begin
			total_expected_q.push_back(tv_sum);
			restart_image();
		end else if (row_pos == nr - 1) begin
			row_pos = 0;
			col_pos++;
		end else begin
			row_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg   = ROWS_RESET;
			cols_reg   = COLUMNS_RESET;
			weights_on = 1'b0;
			for (int n = 0; n < DEPTH; n++) begin
				hist_re[n] = 0;
				hist_im[n] = 0;
				hist_wd[n] = 0;
				hist_wa[n] = 0;
			end
			restart_image();
			total_expected_q.delete();
			errors      = 0;
			pending     = 0;
			totals_seen = 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_ROWS: begin
						rows_reg = pwdata[CFG_W-1:0];
						restart_image();
					end
					REG_COLUMNS: begin
						cols_reg = pwdata[CFG_W-1:0];
						restart_image();
					end
					REG_WEIGHTS: weights_on = pwdata[0];
					default: ;
				endcase
			end
			// result transfer
			if (out_valid && out_ready) begin
				totals_seen++;
				if (total_expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected tv_total expected none actual %0d",
						$time, tv_total);
				end else if (tv_total !== total_expected_q[0]) begin
					errors++;
					$display("%0t: tv_total mismatch expected %0d actual %0d",
						$time, total_expected_q[0], tv_total);
					void'(total_expected_q.pop_front());
				end else begin
					void'(total_expected_q.pop_front());
				end
			end
			// pixel transfer
			if (in_valid && in_ready)
				take_pixel(pixel_re, pixel_im, weight_down, weight_across);
			pending = total_expected_q.size();
		end
	end

endmodule

[bench/weighted_total_variation_norm_test.sv]
`timescale 1ns / 100ps
// Stimulus, clock, reset and verdict for the weighted TV norm testbench.
module weighted_total_variation_norm_test;
	import wtvn_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 100;
	localparam int HOLD_LEN   = 3000;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid, in_ready;
	logic signed [15:0]  pixel_re, pixel_im;
	logic [15:0]         weight_down, weight_across;
	logic                out_valid, out_ready;
	logic [ACC_W-1:0]    tv_total;
	int                  errors, pending, totals_seen;
	int                  pixels_sent, images_sent;
	int                  idle_count = 0;
	int                  hold_requests = 0;
	int                  hold_served = 0;
	int                  hold_cycles = 0;

	weighted_total_variation_norm i_dut (.*);

	wtvn_checker i_checker (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 7) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 16'hffff;
			1: return 16'h0000;
			2: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: random stalls, or a counted long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_cycles <= HOLD_LEN - 1;
			out_ready   <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	// watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_pixel(logic [15:0] re, logic [15:0] im, logic [15:0] wd,
			logic [15:0] wa, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid      = 1'b1;
		pixel_re      = re;
		pixel_im      = im;
		weight_down   = wd;
		weight_across = wa;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_image(int n, bit real_only);
		for (int p = 0; p < n; p++)
			send_pixel(pick_pixel(), real_only ? 16'h0 : pick_pixel(), pick_weight(),
				pick_weight(), 1'b1);
		images_sent++;
	endtask

	// block drained: no total owed and nothing left in flight
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_shape(int r, int c, bit w);
		reg_write(REG_ROWS, r);
		reg_write(REG_COLUMNS, c);
		reg_write(REG_WEIGHTS, w);
	endtask

	initial begin
		int r, c;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; pixel_re = '0; pixel_im = '0;
		weight_down = '0; weight_across = '0;
		pixels_sent = 0; images_sent = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extreme pixels, weighting off then full-scale and zero weights
		set_shape(2, 2, 1'b0);
		send_pixel(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 0);
		send_pixel(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 0);
		send_pixel(16'h8000, 16'h7fff, 16'h1000, 16'h0800, 0);
		send_pixel(16'h7fff, 16'h8000, 16'hffff, 16'h0001, 0);
		drain();
		reg_write(REG_WEIGHTS, 1);
		send_pixel(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 0);
		send_pixel(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 0);
		send_pixel(16'h8000, 16'h0000, 16'h0800, 16'h0001, 0);
		send_pixel(16'h7fff, 16'h0000, 16'hffff, 16'h0000, 0);
		drain();
		// undecoded register index is ignored
		reg_write(2'd3, 32'hffff_ffff);
		// dimension written mid-image restarts it
		set_shape(3, 3, 1'b1);
		send_image(4, 0);
		drain();
		reg_write(REG_COLUMNS, 3);
		send_image(9, 0);
		// weight mode written mid-image keeps the image
		drain();
		send_image(4, 1);
		drain();
		reg_write(REG_WEIGHTS, 0);
		send_image(5, 1);
		drain();

		// both dimensions below range clamp up to 2
		set_shape(0, 1, 1'b1);
		send_image(4, 0);
		drain();
		// one image longer than the line store so its pointer wraps
		set_shape(520, 2, 1'b1);
		send_image(520 * 2, 0);
		drain();

		// receiver holds off across several images so the input stalls
		set_shape(2, 2, 1'b1);
		hold_requests++;
		repeat (4) send_image(4, 0);
		// sender waits for every owed total
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);

		// random shapes and content
		r = pixels_sent;
		while (pixels_sent - r < 400) begin
			drain();
			if ($urandom_range(0, 9) == 0)
				set_shape($urandom_range(2, 64), $urandom_range(2, 8), $urandom_range(0, 1));
			else
				set_shape($urandom_range(2, 10), $urandom_range(2, 10), $urandom_range(0, 1));
			c = $urandom_range(1, 4);
			repeat (c) send_image(i_checker.rows_reg * i_checker.cols_reg,
				$urandom_range(0, 3) == 0);
		end

		drain();
		$display("covered %0d pixels over %0d images, %0d totals checked", pixels_sent,
			images_sent, totals_seen);
		$display("shapes from clamped 2x2 to a line-wrapping 520x2, weighting on and off, long output stall");
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d totals never seen", errors, pending);
			$display("FAIL");
		end
		$finish;
	end

endmodule

[weighted_total_variation_norm.f]
design/wtvn_pkg.sv
design/wtvn_ram.sv
design/weighted_total_variation_norm.sv
bench/wtvn_checker.sv
bench/weighted_total_variation_norm_test.sv
